// ===== rtl/core/rptseq_pkg.sv =====
// package for the ram pattern test sequencer
// types, codes and constants shared by rptseq_ctrl, rptseq_outq and the top level
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rptseq_pkg;

    localparam int unsigned REGION_W       = 17;
    localparam int unsigned WADDR_W        = 16;
    localparam int unsigned DATA_W         = 32;
    localparam int unsigned DEF_PAGE_WORDS = 8;
    localparam int unsigned DEF_ADDR_BITS  = 16;
    localparam int unsigned OUTQ_DEPTH     = 4;

    localparam logic [REGION_W-1:0] REGION_RESET = 17'h10000;
    localparam logic [DATA_W-1:0]   PAT_A        = 32'h5555_5555;
    localparam logic [DATA_W-1:0]   PAT_B        = 32'hAAAA_AAAA;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_READ  = 2'd1,
        KIND_DONE  = 2'd2
    } t_kind;

    typedef enum logic {
        CMD_RUN   = 1'b0,
        CMD_RDATA = 1'b1
    } t_cmd;

    // which read-back the controller is waiting for
    typedef enum logic [1:0] {
        PH_SAVE  = 2'd0,
        PH_CHK_A = 2'd1,
        PH_CHK_B = 2'd2,
        PH_CHK_R = 2'd3
    } t_phase;

    typedef struct packed {
        t_kind               kind;
        logic [WADDR_W-1:0]  word_address;
        logic [DATA_W-1:0]   write_data;
        logic                pass_ok;
        logic                fault;
        logic                startup_done;
        logic                last;
    } t_result;

    // up to two result words produced by one accepted input word
    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

endpackage

`default_nettype wire

// ===== rtl/core/rptseq_ctrl.sv =====
// test sequencing state and per-word result generation
// depends on rptseq_pkg
`timescale 1ns / 1ps
`default_nettype none

module rptseq_ctrl #(
    parameter int unsigned PAGE_WORDS = rptseq_pkg::DEF_PAGE_WORDS,
    parameter int unsigned ADDR_BITS  = rptseq_pkg::DEF_ADDR_BITS
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    input  wire logic                              i_cmd,
    input  wire logic [rptseq_pkg::DATA_W-1:0]     i_read_data,
    input  wire logic [rptseq_pkg::REGION_W-1:0]   i_region_words,
    output rptseq_pkg::t_push                      o_push
);

    localparam int unsigned RW         = rptseq_pkg::REGION_W;
    localparam int unsigned MAX_REGION = (ADDR_BITS >= RW) ? ((1 << RW) - 1) : (1 << ADDR_BITS);
    localparam int unsigned PAGE_MAX   = MAX_REGION / PAGE_WORDS;
    localparam int unsigned PI_W       = (PAGE_MAX > 1) ? $clog2(PAGE_MAX) : 1;
    localparam int unsigned PW_W       = $clog2(PAGE_WORDS + 1);
    localparam int unsigned PROD_W     = PI_W + 1 + PW_W;
    localparam int unsigned XW         = (PROD_W > RW + 1) ? PROD_W : RW + 1;
    localparam logic [XW-1:0] PW_X     = XW'(PAGE_WORDS);
    localparam logic [XW-1:0] LIMIT_X  = (ADDR_BITS >= RW) ? XW'(MAX_REGION + 1)
                                                            : XW'(MAX_REGION);

    logic                               r_startup_mode, n_startup_mode;
    logic [PI_W-1:0]                    r_page_index, n_page_index;
    logic [RW-1:0]                      r_cur_word, n_cur_word;
    logic [RW-1:0]                      r_end_word, n_end_word;
    rptseq_pkg::t_phase                 r_phase, n_phase;
    logic [rptseq_pkg::DATA_W-1:0]      r_saved_word, n_saved_word;
    logic                               r_busy, n_busy;
    logic                               r_fault, n_fault;

    logic [XW-1:0] w_region_x;
    logic [XW-1:0] w_page_start;
    logic [XW-1:0] w_page_stop;
    logic          w_wrap;
    logic [XW-1:0] w_start;
    logic [XW-1:0] w_stop;
    logic          w_empty;
    logic [RW:0]   w_next_word;
    logic          w_check_ok;
    rptseq_pkg::t_push w_push;

    function automatic rptseq_pkg::t_result make_result(
        rptseq_pkg::t_kind                 kind,
        logic [RW-1:0]                     addr,
        logic [rptseq_pkg::DATA_W-1:0]     data,
        logic                              ok,
        logic                              fault,
        logic                              sdone,
        logic                              last
    );
        rptseq_pkg::t_result res;
        res.kind         = kind;
        res.word_address = addr[rptseq_pkg::WADDR_W-1:0];
        res.write_data   = data;
        res.pass_ok      = ok;
        res.fault        = fault;
        res.startup_done = sdone;
        res.last         = last;
        return res;
    endfunction

    // pass bounds
    assign w_region_x   = (XW'(i_region_words) > LIMIT_X) ? LIMIT_X : XW'(i_region_words);
    assign w_page_start = XW'(r_page_index) * PW_X;
    assign w_page_stop  = w_page_start + PW_X;
    // next index reaches the full page count, or there is no full page
    assign w_wrap       = (w_page_stop + PW_X) > w_region_x;
    assign w_start      = r_startup_mode ? '0 : w_page_start;
    assign w_stop       = r_startup_mode ? w_region_x
                        : ((w_page_stop > w_region_x) ? w_region_x : w_page_stop);
    assign w_empty      = w_start >= w_stop;
    assign w_next_word  = {1'b0, r_cur_word} + (RW+1)'(1);

    always_comb begin
        unique case (r_phase)
            rptseq_pkg::PH_SAVE:  w_check_ok = 1'b1;
            rptseq_pkg::PH_CHK_A: w_check_ok = (i_read_data == rptseq_pkg::PAT_A);
            rptseq_pkg::PH_CHK_B: w_check_ok = (i_read_data == rptseq_pkg::PAT_B);
            rptseq_pkg::PH_CHK_R: w_check_ok = (i_read_data == r_saved_word);
            default:              w_check_ok = 1'b1;
        endcase
    end

    always_comb begin
        n_startup_mode = r_startup_mode;
        n_page_index   = r_page_index;
        n_cur_word     = r_cur_word;
        n_end_word     = r_end_word;
        n_phase        = r_phase;
        n_saved_word   = r_saved_word;
        n_busy         = r_busy;
        n_fault        = r_fault;
        w_push         = '0;

        if (i_valid) begin
            if (rptseq_pkg::t_cmd'(i_cmd) == rptseq_pkg::CMD_RUN) begin
                if (!r_busy) begin
                    if (!r_startup_mode) begin
                        n_page_index = w_wrap ? '0 : PI_W'({1'b0, r_page_index} + 1'b1);
                    end
                    if (w_empty) begin
                        n_busy         = 1'b0;
                        n_startup_mode = 1'b0;
                        w_push.count   = 2'd1;
                        w_push.first   = make_result(rptseq_pkg::KIND_DONE, '0, '0,
                                                     1'b1, r_fault, 1'b1, 1'b1);
                    end else begin
                        n_cur_word   = w_start[RW-1:0];
                        n_end_word   = w_stop[RW-1:0];
                        n_phase      = rptseq_pkg::PH_SAVE;
                        n_busy       = 1'b1;
                        w_push.count = 2'd1;
                        w_push.first = make_result(rptseq_pkg::KIND_READ, w_start[RW-1:0], '0,
                                                   1'b0, r_fault, !r_startup_mode, 1'b1);
                    end
                end
            end else if (r_busy) begin
                if (!w_check_ok) begin
                    // mismatch: put the saved word back and fail the pass
                    n_phase        = rptseq_pkg::PH_SAVE;
                    n_busy         = 1'b0;
                    n_fault        = 1'b1;
                    n_startup_mode = 1'b0;
                    w_push.count   = 2'd2;
                    w_push.first   = make_result(rptseq_pkg::KIND_WRITE, r_cur_word,
                                                 r_saved_word, 1'b0, r_fault,
                                                 !r_startup_mode, 1'b0);
                    w_push.second  = make_result(rptseq_pkg::KIND_DONE, '0, '0,
                                                 1'b0, 1'b1, 1'b1, 1'b1);
                end else begin
                    unique case (r_phase)
                        rptseq_pkg::PH_SAVE: begin
                            n_saved_word  = i_read_data;
                            n_phase       = rptseq_pkg::PH_CHK_A;
                            w_push.count  = 2'd2;
                            w_push.first  = make_result(rptseq_pkg::KIND_WRITE, r_cur_word,
                                                        rptseq_pkg::PAT_A, 1'b0, r_fault,
                                                        !r_startup_mode, 1'b0);
                            w_push.second = make_result(rptseq_pkg::KIND_READ, r_cur_word, '0,
                                                        1'b0, r_fault, !r_startup_mode, 1'b1);
                        end
                        rptseq_pkg::PH_CHK_A: begin
                            n_phase       = rptseq_pkg::PH_CHK_B;
                            w_push.count  = 2'd2;
                            w_push.first  = make_result(rptseq_pkg::KIND_WRITE, r_cur_word,
                                                        rptseq_pkg::PAT_B, 1'b0, r_fault,
                                                        !r_startup_mode, 1'b0);
                            w_push.second = make_result(rptseq_pkg::KIND_READ, r_cur_word, '0,
                                                        1'b0, r_fault, !r_startup_mode, 1'b1);
                        end
                        rptseq_pkg::PH_CHK_B: begin
                            n_phase       = rptseq_pkg::PH_CHK_R;
                            w_push.count  = 2'd2;
                            w_push.first  = make_result(rptseq_pkg::KIND_WRITE, r_cur_word,
                                                        r_saved_word, 1'b0, r_fault,
                                                        !r_startup_mode, 1'b0);
                            w_push.second = make_result(rptseq_pkg::KIND_READ, r_cur_word, '0,
                                                        1'b0, r_fault, !r_startup_mode, 1'b1);
                        end
                        rptseq_pkg::PH_CHK_R: begin
                            n_cur_word   = w_next_word[RW-1:0];
                            n_phase      = rptseq_pkg::PH_SAVE;
                            w_push.count = 2'd1;
                            if (w_next_word >= {1'b0, r_end_word}) begin
                                n_busy         = 1'b0;
                                n_startup_mode = 1'b0;
                                w_push.first   = make_result(rptseq_pkg::KIND_DONE, '0, '0,
                                                             1'b1, r_fault, 1'b1, 1'b1);
                            end else begin
                                w_push.first   = make_result(rptseq_pkg::KIND_READ,
                                                             w_next_word[RW-1:0], '0, 1'b0,
                                                             r_fault, !r_startup_mode, 1'b1);
                            end
                        end
                        default: begin
                            n_phase = rptseq_pkg::PH_SAVE;
                        end
                    endcase
                end
            end
        end
    end

    assign o_push = w_push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_startup_mode <= 1'b1;
            r_page_index   <= '0;
            r_cur_word     <= '0;
            r_end_word     <= '0;
            r_phase        <= rptseq_pkg::PH_SAVE;
            r_busy         <= 1'b0;
            r_fault        <= 1'b0;
        end else begin
            r_startup_mode <= n_startup_mode;
            r_page_index   <= n_page_index;
            r_cur_word     <= n_cur_word;
            r_end_word     <= n_end_word;
            r_phase        <= n_phase;
            r_busy         <= n_busy;
            r_fault        <= n_fault;
        end
    end

    always_ff @(posedge i_clk) begin
        r_saved_word <= n_saved_word;
    end

endmodule

`default_nettype wire

// ===== rtl/core/rptseq_outq.sv =====
// small result queue taking up to two words per cycle and giving one when the reader is ready
// depends on rptseq_pkg
`timescale 1ns / 1ps
`default_nettype none

module rptseq_outq (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire rptseq_pkg::t_push  i_push,
    input  wire logic               i_pop_ready,
    output logic                    o_valid,
    output rptseq_pkg::t_result     o_head,
    output logic                    o_room
);

    localparam int unsigned DEPTH = rptseq_pkg::OUTQ_DEPTH;
    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    rptseq_pkg::t_result r_entries [DEPTH];
    logic [PTR_W-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [PTR_W-1:0]    w_wr_ptr_1;
    logic                w_pop;

    assign w_wr_ptr_1 = r_wr_ptr + PTR_W'(1);
    assign w_pop      = o_valid && i_pop_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr + PTR_W'(i_push.count);
        n_rd_ptr = w_pop ? r_rd_ptr + PTR_W'(1) : r_rd_ptr;
        n_count  = r_count + CNT_W'(i_push.count) - CNT_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_entries[r_wr_ptr] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_entries[w_wr_ptr_1] <= i_push.second;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_head  = r_entries[r_rd_ptr];
    // room for the largest burst of one input word
    assign o_room  = (r_count <= CNT_W'(DEPTH - 2));

endmodule

`default_nettype wire

// ===== rtl/core/ram_pattern_test_sequencer.sv =====
// top level of the ram pattern test sequencer (checkerboard memory test master)
// depends on rptseq_pkg, rptseq_ctrl and rptseq_outq
//
// usage:
//   input channel (i_in_valid / o_in_ready) carries one word per command: i_cmd = 0 is
//   a run request, i_cmd = 1 hands back the data of the last memory read
//   output channel (o_out_valid / i_out_ready) carries memory writes, read requests
//   and pass complete words; o_last marks the final word caused by one input word
//   i_cfg_wr_en / i_cfg_wr_data set region_words; write it only while the block is idle
// latency: the first result of an input word is offered the cycle after it is accepted
//   when the queue is empty, otherwise it waits behind the older results
// throughput: one input word per cycle while the result queue has room for two words;
//   an input word makes up to two results and the output takes one per cycle while
//   i_out_ready is high, so a steady stream of read-back words is paced by the output,
//   which is then busy every cycle
// stall: a four-entry result queue sits between the controller and the output; while
//   the receiver holds i_out_ready low, input words keep being taken until fewer than
//   two free entries remain, then o_in_ready drops; nothing is lost or repeated
// reset: synchronous active low; region_words returns to 65536, the first pass after
//   reset covers the whole region, the fault flag clears and the queue empties
`timescale 1ns / 1ps
`default_nettype none

module ram_pattern_test_sequencer #(
    parameter int unsigned PAGE_WORDS = rptseq_pkg::DEF_PAGE_WORDS,
    parameter int unsigned ADDR_BITS  = rptseq_pkg::DEF_ADDR_BITS
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration write
    input  wire logic                              i_cfg_wr_en,
    input  wire logic [rptseq_pkg::REGION_W-1:0]   i_cfg_wr_data,
    // input words
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic                              i_cmd,
    input  wire logic [rptseq_pkg::DATA_W-1:0]     i_read_data,
    // result words
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic [1:0]                             o_kind,
    output logic [rptseq_pkg::WADDR_W-1:0]         o_word_address,
    output logic [rptseq_pkg::DATA_W-1:0]          o_write_data,
    output logic                                   o_pass_ok,
    output logic                                   o_fault,
    output logic                                   o_startup_done,
    output logic                                   o_last
);

    // region size register
    logic [rptseq_pkg::REGION_W-1:0] r_region_words;

    logic                 w_in_accept;
    logic                 w_room;
    rptseq_pkg::t_push    w_push;
    rptseq_pkg::t_result  w_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region_words <= rptseq_pkg::REGION_RESET;
        end else if (i_cfg_wr_en) begin
            r_region_words <= i_cfg_wr_data;
        end
    end

    // ready depends only on queue fill, never on the output side handshake
    assign o_in_ready  = w_room;
    assign w_in_accept = i_in_valid && w_room;

    // phase tracking, pattern compare and address stepping for each accepted word
    rptseq_ctrl #(
        .PAGE_WORDS (PAGE_WORDS),
        .ADDR_BITS  (ADDR_BITS)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (w_in_accept),
        .i_cmd          (i_cmd),
        .i_read_data    (i_read_data),
        .i_region_words (r_region_words),
        .o_push         (w_push)
    );

    // results wait here until the receiver takes them
    rptseq_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_pop_ready (i_out_ready),
        .o_valid     (o_out_valid),
        .o_head      (w_head),
        .o_room      (w_room)
    );

    assign o_kind         = w_head.kind;
    assign o_word_address = w_head.word_address;
    assign o_write_data   = w_head.write_data;
    assign o_pass_ok      = w_head.pass_ok;
    assign o_fault        = w_head.fault;
    assign o_startup_done = w_head.startup_done;
    assign o_last         = w_head.last;

endmodule

`default_nettype wire
